// ===== design/sqt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the shell quote tokenizer.
// No dependencies; used by sqt_core, sqt_emit and shell_quote_tokenizer.

package sqt_pkg;

    // Characters with a special meaning
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_BTICK  = 8'h60;

    // Input item codes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    // Token type codes carried on a token end
    localparam logic [2:0] TT_WORD    = 3'd0;
    localparam logic [2:0] TT_SINGLE  = 3'd1;
    localparam logic [2:0] TT_DOUBLE  = 3'd2;
    localparam logic [2:0] TT_GT      = 3'd3;
    localparam logic [2:0] TT_GTGT    = 3'd4;
    localparam logic [2:0] TT_TWOGT   = 3'd5;
    localparam logic [2:0] TT_TWOGTGT = 3'd6;

    // Most results one input item can cause
    localparam int MAX_RES = 4;

    typedef enum logic [1:0] {
        KIND_CONTENT = 2'd0,
        KIND_END     = 2'd1,
        KIND_EOL     = 2'd2
    } t_kind;

    // Quoting mode, one-hot
    typedef enum logic [3:0] {
        M_NORMAL = 4'b0001,
        M_SINGLE = 4'b0010,
        M_DOUBLE = 4'b0100,
        M_ESCAPE = 4'b1000
    } t_mode;

    // Held-back lookahead, one-hot
    typedef enum logic [3:0] {
        P_NONE  = 4'b0001,
        P_GT    = 4'b0010,
        P_TWO   = 4'b0100,
        P_TWOGT = 4'b1000
    } t_pend;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [2:0] ttype;
    } t_result;

    // All results of one input item, in order, with their count
    typedef struct packed {
        t_result [MAX_RES-1:0] res;
        logic [$clog2(MAX_RES+1)-1:0] cnt;
    } t_bundle;

endpackage

// ===== design/sqt_core.sv =====
`timescale 1ns / 1ps
// Tokenizer state and the single-pass step logic that turns one input item
// into a bundle of up to four results. Depends on sqt_pkg.

module sqt_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_op,
    input  logic [7:0]          i_char_byte,
    output sqt_pkg::t_bundle    o_bundle
);

    sqt_pkg::t_mode r_mode, n_mode;
    sqt_pkg::t_pend r_pend, n_pend;
    logic           r_esc_dq, n_esc_dq;
    logic           r_tok_open, n_tok_open;

    // Append one result to a bundle
    function automatic sqt_pkg::t_bundle push(input sqt_pkg::t_bundle b,
                                              input sqt_pkg::t_kind k,
                                              input logic [7:0] d,
                                              input logic [2:0] t);
        sqt_pkg::t_bundle r;
        r = b;
        r.res[b.cnt[1:0]] = '{kind: k, data: d, ttype: t};
        r.cnt = b.cnt + 1'b1;
        return r;
    endfunction

    // Step: resolve lookahead, then mode, then the plain-byte rules
    always_comb begin
        sqt_pkg::t_bundle b;
        logic             do_normal;
        logic [7:0]       c;

        b          = '0;
        do_normal  = 1'b0;
        c          = i_char_byte;
        n_mode     = r_mode;
        n_pend     = r_pend;
        n_esc_dq   = r_esc_dq;
        n_tok_open = r_tok_open;

        if (i_op == sqt_pkg::OP_EOL) begin
            // flush held-back operator or digit
            case (r_pend)
                sqt_pkg::P_GT: begin
                    b = push(b, sqt_pkg::KIND_CONTENT, sqt_pkg::CH_GT, 3'd0);
                    b = push(b, sqt_pkg::KIND_END, 8'd0, sqt_pkg::TT_GT);
                    n_tok_open = 1'b0;
                end
                sqt_pkg::P_TWO: begin
                    b = push(b, sqt_pkg::KIND_CONTENT, sqt_pkg::CH_TWO, 3'd0);
                    n_tok_open = 1'b1;
                end
                sqt_pkg::P_TWOGT: begin
                    b = push(b, sqt_pkg::KIND_CONTENT, sqt_pkg::CH_TWO, 3'd0);
                    b = push(b, sqt_pkg::KIND_CONTENT, sqt_pkg::CH_GT, 3'd0);
                    b = push(b, sqt_pkg::KIND_END, 8'd0, sqt_pkg::TT_TWOGT);
                    n_tok_open = 1'b0;
                end
                default: ;
            endcase
            // keep a dangling backslash inside double quotes
            if (r_mode == sqt_pkg::M_ESCAPE && r_esc_dq) begin
                b = push(b, sqt_pkg::KIND_CONTENT, sqt_pkg::CH_BSLASH, 3'd0);
                n_tok_open = 1'b1;
            end
            if (n_tok_open)
                b = push(b, sqt_pkg::KIND_END, 8'd0, sqt_pkg::TT_WORD);
            b = push(b, sqt_pkg::KIND_EOL, 8'd0, 3'd0);
            n_mode     = sqt_pkg::M_NORMAL;
            n_pend     = sqt_pkg::P_NONE;
            n_esc_dq   = 1'b0;
            n_tok_open = 1'b0;
        end else begin
            case (r_pend)
                sqt_pkg::P_GT: begin
                    n_pend = sqt_pkg::P_NONE;
                    b = push(b, sqt_pkg::KIND_CONTENT, sqt_pkg::CH_GT, 3'd0);
                    if (c == sqt_pkg::CH_GT) begin
                        b = push(b, sqt_pkg::KIND_CONTENT, sqt_pkg::CH_GT, 3'd0);
                        b = push(b, sqt_pkg::KIND_END, 8'd0, sqt_pkg::TT_GTGT);
                    end else begin
                        b = push(b, sqt_pkg::KIND_END, 8'd0, sqt_pkg::TT_GT);
                        do_normal = 1'b1;
                    end
                    n_tok_open = 1'b0;
                end
                sqt_pkg::P_TWO: begin
                    if (c == sqt_pkg::CH_GT) begin
                        // the digit belongs to the operator: end the word first
                        if (r_tok_open)
                            b = push(b, sqt_pkg::KIND_END, 8'd0, sqt_pkg::TT_WORD);
                        n_tok_open = 1'b0;
                        n_pend     = sqt_pkg::P_TWOGT;
                    end else begin
                        n_pend = sqt_pkg::P_NONE;
                        b = push(b, sqt_pkg::KIND_CONTENT, sqt_pkg::CH_TWO, 3'd0);
                        n_tok_open = 1'b1;
                        do_normal  = 1'b1;
                    end
                end
                sqt_pkg::P_TWOGT: begin
                    n_pend = sqt_pkg::P_NONE;
                    b = push(b, sqt_pkg::KIND_CONTENT, sqt_pkg::CH_TWO, 3'd0);
                    b = push(b, sqt_pkg::KIND_CONTENT, sqt_pkg::CH_GT, 3'd0);
                    if (c == sqt_pkg::CH_GT) begin
                        b = push(b, sqt_pkg::KIND_CONTENT, sqt_pkg::CH_GT, 3'd0);
                        b = push(b, sqt_pkg::KIND_END, 8'd0, sqt_pkg::TT_TWOGTGT);
                    end else begin
                        b = push(b, sqt_pkg::KIND_END, 8'd0, sqt_pkg::TT_TWOGT);
                        do_normal = 1'b1;
                    end
                    n_tok_open = 1'b0;
                end
                default: begin
                    case (r_mode)
                        sqt_pkg::M_NORMAL: do_normal = 1'b1;
                        sqt_pkg::M_SINGLE: begin
                            if (c == sqt_pkg::CH_SQUOTE) begin
                                b = push(b, sqt_pkg::KIND_END, 8'd0, sqt_pkg::TT_SINGLE);
                                n_tok_open = 1'b0;
                                n_mode     = sqt_pkg::M_NORMAL;
                            end else begin
                                b = push(b, sqt_pkg::KIND_CONTENT, c, 3'd0);
                                n_tok_open = 1'b1;
                            end
                        end
                        sqt_pkg::M_DOUBLE: begin
                            if (c == sqt_pkg::CH_BSLASH) begin
                                n_mode   = sqt_pkg::M_ESCAPE;
                                n_esc_dq = 1'b1;
                            end else if (c == sqt_pkg::CH_DQUOTE) begin
                                b = push(b, sqt_pkg::KIND_END, 8'd0, sqt_pkg::TT_DOUBLE);
                                n_tok_open = 1'b0;
                                n_mode     = sqt_pkg::M_NORMAL;
                            end else begin
                                b = push(b, sqt_pkg::KIND_CONTENT, c, 3'd0);
                                n_tok_open = 1'b1;
                            end
                        end
                        default: begin
                            // escaped byte
                            if (r_esc_dq) begin
                                if (!(c == sqt_pkg::CH_DQUOTE || c == sqt_pkg::CH_BSLASH ||
                                      c == sqt_pkg::CH_DOLLAR || c == sqt_pkg::CH_BTICK))
                                    b = push(b, sqt_pkg::KIND_CONTENT, sqt_pkg::CH_BSLASH,
                                             3'd0);
                                n_mode = sqt_pkg::M_DOUBLE;
                            end else begin
                                n_mode = sqt_pkg::M_NORMAL;
                            end
                            b = push(b, sqt_pkg::KIND_CONTENT, c, 3'd0);
                            n_tok_open = 1'b1;
                            n_esc_dq   = 1'b0;
                        end
                    endcase
                end
            endcase

            // plain-mode handling of the current byte
            if (do_normal) begin
                if (c == sqt_pkg::CH_SQUOTE || c == sqt_pkg::CH_DQUOTE ||
                    c == sqt_pkg::CH_GT || c == sqt_pkg::CH_SPACE) begin
                    if (n_tok_open)
                        b = push(b, sqt_pkg::KIND_END, 8'd0, sqt_pkg::TT_WORD);
                    n_tok_open = 1'b0;
                    if (c == sqt_pkg::CH_SQUOTE)
                        n_mode = sqt_pkg::M_SINGLE;
                    else if (c == sqt_pkg::CH_DQUOTE)
                        n_mode = sqt_pkg::M_DOUBLE;
                    else if (c == sqt_pkg::CH_GT)
                        n_pend = sqt_pkg::P_GT;
                end else if (c == sqt_pkg::CH_BSLASH) begin
                    n_mode   = sqt_pkg::M_ESCAPE;
                    n_esc_dq = 1'b0;
                end else if (c == sqt_pkg::CH_TWO) begin
                    n_pend = sqt_pkg::P_TWO;
                end else begin
                    b = push(b, sqt_pkg::KIND_CONTENT, c, 3'd0);
                    n_tok_open = 1'b1;
                end
            end
        end

        o_bundle = b;
    end

    // Advance state on each loaded item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= sqt_pkg::M_NORMAL;
            r_pend     <= sqt_pkg::P_NONE;
            r_esc_dq   <= 1'b0;
            r_tok_open <= 1'b0;
        end else if (i_load) begin
            r_mode     <= n_mode;
            r_pend     <= n_pend;
            r_esc_dq   <= n_esc_dq;
            r_tok_open <= n_tok_open;
        end
    end

endmodule

// ===== design/sqt_emit.sv =====
`timescale 1ns / 1ps
// Result register: holds one bundle and hands its results out one transfer
// per cycle while i_stall is low. Depends on sqt_pkg.

module sqt_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load_req,
    input  sqt_pkg::t_bundle    i_bundle,
    output logic                o_can_load,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_kind,
    output logic [7:0]          o_data_byte,
    output logic [2:0]          o_token_type,
    output logic                o_last_of_run
);

    localparam int CntW = $clog2(sqt_pkg::MAX_RES + 1);
    localparam int IdxW = $clog2(sqt_pkg::MAX_RES);

    sqt_pkg::t_result [sqt_pkg::MAX_RES-1:0] r_res;
    logic [CntW-1:0] r_cnt;
    logic [IdxW-1:0] r_idx;

    logic xfer;
    logic is_last;
    logic load;

    assign o_valid    = (r_cnt != '0);
    assign xfer       = o_valid && !i_stall;
    assign is_last    = ({1'b0, r_idx} + 1'b1) == r_cnt;
    assign o_can_load = !o_valid || (xfer && is_last);
    assign load       = i_load_req && o_can_load;

    assign o_kind        = r_res[r_idx].kind;
    assign o_data_byte   = r_res[r_idx].data;
    assign o_token_type  = r_res[r_idx].ttype;
    assign o_last_of_run = is_last;

    // Count and index: reload, drop the finished bundle, or advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (load) begin
            r_cnt <= i_bundle.cnt;
            r_idx <= '0;
        end else if (xfer && is_last) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (xfer) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Payload of the bundle
    always_ff @(posedge i_clk) begin
        if (load)
            r_res <= i_bundle.res;
    end

endmodule

// ===== design/shell_quote_tokenizer.sv =====
`timescale 1ns / 1ps
// Shell quote tokenizer, top level: input register, step logic, result
// register. Depends on sqt_pkg, sqt_core and sqt_emit.
//
// Input channel: i_valid / o_stall with i_op (0 = byte, 1 = end of line)
// and i_char_byte. Output channel: o_valid / i_stall with o_kind (content,
// token end, end of line), o_data_byte, o_token_type and o_last_of_run,
// which marks the final result caused by one input item.
// An accepted item waits in the input register until the result register
// can take it; then the step logic updates the tokenizer state and loads
// its zero to four results into the result register. Results leave one per
// cycle while i_stall is low, one result at a time; the next item's bundle
// loads in the same cycle as the current one's last result transfers out.
// Items that cause no result (held-back lookahead, quote opens) leave the
// output idle. While the receiver stalls, the current result holds; the
// input register still takes one more item, then o_stall rises.
// Reset (synchronous, active low) empties both registers and returns the
// tokenizer to plain mode with no open token and nothing held back.

module shell_quote_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_op,
    input  logic [7:0] i_char_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_data_byte,
    output logic [2:0] o_token_type,
    output logic       o_last_of_run
);

    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_char;

    logic             can_load;
    logic             load;
    logic             accept;
    sqt_pkg::t_bundle bundle;

    assign load    = r_in_valid && can_load;
    assign o_stall = r_in_valid && !can_load;
    assign accept  = i_valid && !o_stall;

    // Input register: fill on a transfer in, empty when its item is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_op   <= i_op;
            r_in_char <= i_char_byte;
        end
    end

    sqt_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_op        (r_in_op),
        .i_char_byte (r_in_char),
        .o_bundle    (bundle)
    );

    sqt_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load_req    (r_in_valid),
        .i_bundle      (bundle),
        .o_can_load    (can_load),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_data_byte   (o_data_byte),
        .o_token_type  (o_token_type),
        .o_last_of_run (o_last_of_run)
    );

endmodule
